// ----- design/ugff_pkg.sv -----
// Shared types and constants for the uncompressed GIF frame framer.
// Used by the front end, the command queue and the byte sequencer.
package ugff_pkg;

   localparam int CSR_INDEX_BITS = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_DELAY  = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_TOTAL  = 8'd3;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] EXT_INTRODUCER = 8'h21;
   localparam logic [7:0] GCE_LABEL      = 8'hF9;
   localparam logic [7:0] GCE_SIZE       = 8'h04;
   localparam logic [7:0] IMAGE_SEP      = 8'h2C;
   localparam logic [7:0] END_BLOCK_LEN  = 8'h01;
   localparam logic [7:0] ZERO_BYTE      = 8'h00;
   localparam logic [7:0] TRAILER_BYTE   = 8'h3B;

   typedef struct packed {
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [15:0] frame_delay;
      logic [15:0] frame_total;
   } cfg_type;

   typedef struct packed {
      logic header;
      logic block;
      logic frame_end;
      logic trailer;
   } frame_cmd_type;

   localparam int CMD_BITS = $bits(frame_cmd_type);

endpackage

// ----- design/uncompressed_gif_frame_framer_unit.sv -----
// Uncompressed GIF frame framer. Each pixel transaction on req_ becomes 1 to 26
// bytes on rsp_, the last one flagged by rsp_tlast; the byte sequencer sends one
// byte per cycle while rsp_tready is high. A pixel inside a sub-block gives one
// byte, a sub-block start three, and frame starts and ends up to 26. A
// four-entry command queue lets pixels be taken while earlier bytes drain.
// After a register write, req_tready drops for one cycle while the frame size
// product is recomputed. Depends on ugff_pkg, ugff_front, ugff_queue, ugff_back.
module uncompressed_gif_frame_framer_unit #(
   parameter int PIXEL_BITS = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ugff_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0]                         csr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [6:0] pixel, [7] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,  // [7:0] out_byte
   output logic                                rsp_tlast
);
   import ugff_pkg::*;

   localparam int ENTRY_BITS = CMD_BITS + 2 * PIXEL_BITS;

   cfg_type               cfg;
   logic                  queue_ready, queue_push, cmd_valid, cmd_pop;
   logic [ENTRY_BITS-1:0] queue_entry, cmd_entry;

   ugff_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .queue_ready (queue_ready),
      .queue_push  (queue_push),
      .queue_entry (queue_entry),
      .cfg         (cfg)
   );

   ugff_queue #(.WIDTH(ENTRY_BITS)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_data  (queue_entry),
      .push_ready (queue_ready),
      .pop        (cmd_pop),
      .pop_valid  (cmd_valid),
      .pop_data   (cmd_entry)
   );

   ugff_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd_valid  (cmd_valid),
      .cmd_entry  (cmd_entry),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- design/ugff_front.sv -----
// Front end of the framer: configuration registers, frame and sub-block
// counters, and classification of each pixel into a queued command.
// Depends on ugff_pkg.
module ugff_front #(
   parameter int PIXEL_BITS = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ugff_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0]                         csr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,
   input  logic                                queue_ready,
   output logic                                queue_push,
   output logic [ugff_pkg::CMD_BITS+2*PIXEL_BITS-1:0] queue_entry,
   output ugff_pkg::cfg_type                   cfg
);
   import ugff_pkg::*;

   localparam logic [PIXEL_BITS-1:0] BLOCK_MAX = PIXEL_BITS'((1 << PIXEL_BITS) - 2);

   cfg_type       cfg_ff, cfg_in;
   logic          hold_ff;
   logic [31:0]   frame_size_ff, frame_size_in;
   logic [31:0]   pixel_index_ff, pixel_index_in;
   logic [PIXEL_BITS-1:0] block_fill_ff, block_fill_in;
   logic [15:0]   frame_index_ff, frame_index_in;

   logic [32:0]   diff;
   logic          ahead, done, last_frame;
   logic [31:0]   left;
   logic [PIXEL_BITS-1:0] left_clamped, len_byte, fill, fill_inc;
   logic [15:0]   frame_limit;
   logic [31:0]   product;
   frame_cmd_type cmd;
   logic          accept;

   assign csr_ready  = 1'b1;
   assign req_tready = queue_ready && !hold_ff;
   assign accept     = req_tvalid && req_tready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_data;
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_data;
            CSR_FRAME_DELAY:  cfg_in.frame_delay  = csr_data;
            CSR_FRAME_TOTAL:  cfg_in.frame_total  = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   assign product       = cfg_ff.image_width * cfg_ff.image_height;
   assign frame_size_in = (product == 32'd0) ? 32'd1 : product;

   always_comb begin
      diff  = {1'b0, frame_size_ff} - {1'b0, pixel_index_ff};
      ahead = !diff[32] && (diff != 33'd0);
      done  = diff[32] || (diff[32:1] == 32'd0);
      left  = ahead ? diff[31:0] : 32'd1;
      left_clamped = (left > {{(32-PIXEL_BITS){1'b0}}, BLOCK_MAX}) ?
                     BLOCK_MAX : left[PIXEL_BITS-1:0];
      len_byte = left_clamped + PIXEL_BITS'(1);

      frame_limit = (cfg_ff.frame_total == 16'd0) ? 16'd1 : cfg_ff.frame_total;
      last_frame  = ({1'b0, frame_index_ff} + 17'd1) >= {1'b0, frame_limit};

      cmd.header    = (pixel_index_ff == 32'd0);
      fill          = cmd.header ? '0 : block_fill_ff;
      cmd.block     = (fill == '0);
      cmd.frame_end = done;
      cmd.trailer   = done && last_frame;
      fill_inc      = fill + PIXEL_BITS'(1);

      pixel_index_in = pixel_index_ff;
      block_fill_in  = block_fill_ff;
      frame_index_in = frame_index_ff;
      if (accept) begin
         if (done) begin
            pixel_index_in = 32'd0;
            block_fill_in  = '0;
            frame_index_in = last_frame ? 16'd0 : frame_index_ff + 16'd1;
         end else begin
            pixel_index_in = pixel_index_ff + 32'd1;
            block_fill_in  = (fill_inc >= BLOCK_MAX) ? '0 : fill_inc;
         end
      end
   end

   assign queue_push  = accept;
   assign queue_entry = {cmd, len_byte, req_tdata[PIXEL_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= 16'd256;
         cfg_ff.image_height <= 16'd256;
         cfg_ff.frame_delay  <= 16'd2;
         cfg_ff.frame_total  <= 16'd1;
         hold_ff        <= 1'b0;
         frame_size_ff  <= 32'd65536;
         pixel_index_ff <= 32'd0;
         block_fill_ff  <= '0;
         frame_index_ff <= 16'd0;
      end else begin
         cfg_ff         <= cfg_in;
         hold_ff        <= csr_valid;
         frame_size_ff  <= frame_size_in;
         pixel_index_ff <= pixel_index_in;
         block_fill_ff  <= block_fill_in;
         frame_index_ff <= frame_index_in;
      end
   end

endmodule

// ----- design/ugff_queue.sv -----
// Short command queue between the framer front end and the byte sequencer.
// Depends on ugff_pkg for its depth.
module ugff_queue #(
   parameter int WIDTH = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   import ugff_pkg::*;

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]      entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != COUNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + COUNT_BITS'(do_push) - COUNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/ugff_back.sv -----
// Byte sequencer of the framer: walks the byte slots of each queued command
// and drives the registered result stream. Depends on ugff_pkg.
module ugff_back #(
   parameter int PIXEL_BITS = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  ugff_pkg::cfg_type   cfg,
   input  logic                cmd_valid,
   input  logic [ugff_pkg::CMD_BITS+2*PIXEL_BITS-1:0] cmd_entry,
   output logic                cmd_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);
   import ugff_pkg::*;

   localparam logic [4:0] SLOT_FIRST      = 5'd0;
   localparam logic [4:0] SLOT_DELAY_LO   = 5'd4;
   localparam logic [4:0] SLOT_DELAY_HI   = 5'd5;
   localparam logic [4:0] SLOT_SEPARATOR  = 5'd8;
   localparam logic [4:0] SLOT_WIDTH_LO   = 5'd13;
   localparam logic [4:0] SLOT_WIDTH_HI   = 5'd14;
   localparam logic [4:0] SLOT_HEIGHT_LO  = 5'd15;
   localparam logic [4:0] SLOT_HEIGHT_HI  = 5'd16;
   localparam logic [4:0] SLOT_CODE_SIZE  = 5'd18;
   localparam logic [4:0] SLOT_BLOCK_LEN  = 5'd19;
   localparam logic [4:0] SLOT_CLEAR      = 5'd20;
   localparam logic [4:0] SLOT_PIXEL      = 5'd21;
   localparam logic [4:0] SLOT_END_LEN    = 5'd22;
   localparam logic [4:0] SLOT_STOP       = 5'd23;
   localparam logic [4:0] SLOT_TERMINATOR = 5'd24;
   localparam logic [4:0] SLOT_TRAILER    = 5'd25;

   localparam logic [7:0] CLEAR_CODE = 8'(1 << PIXEL_BITS);
   localparam logic [7:0] STOP_CODE  = 8'((1 << PIXEL_BITS) + 1);

   frame_cmd_type         cmd;
   logic [PIXEL_BITS-1:0] len_byte, pix;
   logic                  busy_ff, busy_in;
   logic [4:0]            slot_ff, slot_in, cur, nxt;
   logic                  last;
   logic [7:0]            byte_val;
   logic                  advance, emit;
   logic                  valid_ff, valid_in, tlast_ff, tlast_in;
   logic [7:0]            data_ff, data_in;

   assign {cmd, len_byte, pix} = cmd_entry;
   assign advance = !valid_ff || rsp_tready;
   assign emit    = advance && cmd_valid;

   always_comb begin
      if (busy_ff) begin
         cur = slot_ff;
      end else if (cmd.header) begin
         cur = SLOT_FIRST;
      end else if (cmd.block) begin
         cur = SLOT_BLOCK_LEN;
      end else begin
         cur = SLOT_PIXEL;
      end

      last = 1'b0;
      nxt  = cur + 5'd1;
      priority if (cur == SLOT_CODE_SIZE) begin
         nxt = cmd.block ? SLOT_BLOCK_LEN : SLOT_PIXEL;
      end else if (cur == SLOT_PIXEL) begin
         last = !cmd.frame_end;
      end else if (cur == SLOT_TERMINATOR) begin
         last = !cmd.trailer;
      end else if (cur == SLOT_TRAILER) begin
         last = 1'b1;
      end else begin
         last = 1'b0;
      end

      unique case (cur)
         5'd0:            byte_val = EXT_INTRODUCER;
         5'd1:            byte_val = GCE_LABEL;
         5'd2:            byte_val = GCE_SIZE;
         SLOT_DELAY_LO:   byte_val = cfg.frame_delay[7:0];
         SLOT_DELAY_HI:   byte_val = cfg.frame_delay[15:8];
         SLOT_SEPARATOR:  byte_val = IMAGE_SEP;
         SLOT_WIDTH_LO:   byte_val = cfg.image_width[7:0];
         SLOT_WIDTH_HI:   byte_val = cfg.image_width[15:8];
         SLOT_HEIGHT_LO:  byte_val = cfg.image_height[7:0];
         SLOT_HEIGHT_HI:  byte_val = cfg.image_height[15:8];
         SLOT_CODE_SIZE:  byte_val = 8'(PIXEL_BITS);
         SLOT_BLOCK_LEN:  byte_val = 8'(len_byte);
         SLOT_CLEAR:      byte_val = CLEAR_CODE;
         SLOT_PIXEL:      byte_val = 8'(pix);
         SLOT_END_LEN:    byte_val = END_BLOCK_LEN;
         SLOT_STOP:       byte_val = STOP_CODE;
         SLOT_TRAILER:    byte_val = TRAILER_BYTE;
         default:         byte_val = ZERO_BYTE;
      endcase

      busy_in  = busy_ff;
      slot_in  = slot_ff;
      valid_in = advance ? cmd_valid : valid_ff;
      data_in  = data_ff;
      tlast_in = tlast_ff;
      if (emit) begin
         busy_in  = !last;
         slot_in  = nxt;
         data_in  = byte_val;
         tlast_in = last;
      end
   end

   assign cmd_pop    = emit && last;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = tlast_ff;

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      tlast_ff <= tlast_in;
      slot_ff  <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- design/ugff_checker.sv -----
// Port-level checks for the uncompressed GIF frame framer, bound to its top
// level. Depends on ugff_pkg for the register index width and indices.
module ugff_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [ugff_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [7:0]                          rsp_tdata,
   input logic                                rsp_tlast
);
   import ugff_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_csr_pause: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_tready)
      else $error("pixel accepted right after a register write");

   a_csr_always_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid && (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT
                    || csr_index == CSR_FRAME_DELAY || csr_index == CSR_FRAME_TOTAL)
      |-> csr_ready)
      else $error("register write not taken");

endmodule

bind uncompressed_gif_frame_framer_unit ugff_checker u_ugff_checker (
   .clock      (clock),
   .reset      (reset),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_index  (csr_index),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for uncompressed_gif_frame_framer_unit.
// Streams gray pixels through a random-gap driver and checks every GIF byte against a
// built-in byte predictor; depends on ugff_pkg and the design files.
module testbench;
   import ugff_pkg::*;

   localparam int PIXEL_BITS = 7;
   localparam logic [7:0] CLEAR_CODE = 8'd1 << PIXEL_BITS;
   localparam logic [7:0] STOP_CODE = CLEAR_CODE + 8'd1;
   localparam longint unsigned BLOCK_MAX = (longint'(1) << PIXEL_BITS) - 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LO = 8'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_HI = 8'hFF;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS = 230;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } gif_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   cfg_type         cfg;
   logic [31:0]     pixel_pos;
   logic [6:0]      fill_cnt;
   logic [15:0]     frames_done;
   gif_byte_type    gif_bytes_q[$];
   logic [6:0]      pending_pixels[$];
   int unsigned     req_gap;
   int unsigned     rsp_stall;
   int unsigned     stall_draw;
   bit              no_idle = 1'b0;
   int              err_count = 0;
   gif_byte_type    want;

   uncompressed_gif_frame_framer_unit #(.PIXEL_BITS(PIXEL_BITS)) dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      err_count++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_byte(input logic [7:0] b);
      gif_byte_type e;
      e.data = b;
      e.last = 1'b0;
      gif_bytes_q.push_back(e);
   endtask

   // Appends every byte that one accepted pixel produces and advances the framing state.
   task automatic emit_gif_bytes(input logic [6:0] px);
      longint unsigned w;
      longint unsigned h;
      longint unsigned fsize;
      longint unsigned left;
      longint unsigned last_frame;
      gif_byte_type    e;
      w = cfg.image_width;
      h = cfg.image_height;
      fsize = w * h;
      if (fsize == 0) fsize = 1;
      last_frame = (cfg.frame_total == 0) ? 1 : cfg.frame_total;
      if (pixel_pos == 0) begin
         push_byte(EXT_INTRODUCER);
         push_byte(GCE_LABEL);
         push_byte(GCE_SIZE);
         push_byte(ZERO_BYTE);
         push_byte(cfg.frame_delay[7:0]);
         push_byte(cfg.frame_delay[15:8]);
         push_byte(ZERO_BYTE);
         push_byte(ZERO_BYTE);
         push_byte(IMAGE_SEP);
         repeat (4) push_byte(ZERO_BYTE);
         push_byte(cfg.image_width[7:0]);
         push_byte(cfg.image_width[15:8]);
         push_byte(cfg.image_height[7:0]);
         push_byte(cfg.image_height[15:8]);
         push_byte(ZERO_BYTE);
         push_byte(8'(PIXEL_BITS));
         fill_cnt = '0;
      end
      if (fill_cnt == 0) begin
         left = (longint'(pixel_pos) < fsize) ? fsize - pixel_pos : 1;
         if (left > BLOCK_MAX) left = BLOCK_MAX;
         push_byte(8'(left + 1));
         push_byte(CLEAR_CODE);
      end
      push_byte({1'b0, px & 7'((1 << PIXEL_BITS) - 1)});
      fill_cnt = fill_cnt + 7'd1;
      if (fill_cnt >= BLOCK_MAX) fill_cnt = '0;
      if (longint'(pixel_pos) + 1 >= fsize) begin
         push_byte(END_BLOCK_LEN);
         push_byte(STOP_CODE);
         push_byte(ZERO_BYTE);
         pixel_pos = '0;
         fill_cnt = '0;
         if (longint'(frames_done) + 1 >= last_frame) begin
            push_byte(TRAILER_BYTE);
            frames_done = '0;
         end else begin
            frames_done = frames_done + 16'd1;
         end
      end else begin
         pixel_pos = pixel_pos + 32'd1;
      end
      e = gif_bytes_q.pop_back();
      e.last = 1'b1;
      gif_bytes_q.push_back(e);
   endtask

   // Pixel driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) emit_gif_bytes(req_tdata[6:0]);
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               req_tdata <= {1'b0, pending_pixels.pop_front()};
               req_tvalid <= 1'b1;
               req_gap <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Byte monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (gif_bytes_q.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %0b", rsp_tdata, rsp_tlast));
            end else begin
               want = gif_bytes_q.pop_front();
               if (rsp_tdata !== want.data)
                  report_mismatch($sformatf("byte %02h, expected %02h", rsp_tdata, want.data));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("tlast %0b, expected %0b on byte %02h",
                                            rsp_tlast, want.last, want.data));
            end
         end
         if (rsp_stall != 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_tready <= (rsp_stall == 1);
         end else if (rsp_tvalid && rsp_tready) begin
            stall_draw = pick_gap();
            rsp_tready <= (stall_draw == 0);
            rsp_stall <= stall_draw;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Waits until every pixel is taken and every byte has come, then lets the block settle.
   task automatic drain();
      @(negedge clock);
      while (pending_pixels.size() != 0 || req_tvalid || gif_bytes_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [15:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_IMAGE_WIDTH:  cfg.image_width = val;
         CSR_IMAGE_HEIGHT: cfg.image_height = val;
         CSR_FRAME_DELAY:  cfg.frame_delay = val;
         CSR_FRAME_TOTAL:  cfg.frame_total = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(input logic [6:0] px);
      pending_pixels.push_back(px);
   endtask

   task automatic send_random(input int count);
      @(negedge clock);
      repeat (count) pending_pixels.push_back(7'($urandom_range(0, 127)));
   endtask

   initial begin
      int          sent;
      int unsigned roll;
      cfg.image_width = 16'd256;
      cfg.image_height = 16'd256;
      cfg.frame_delay = 16'd2;
      cfg.frame_total = 16'd1;
      pixel_pos = '0;
      fill_cnt = '0;
      frames_done = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      send_pixel(7'd0);
      send_pixel(7'd127);
      send_pixel(7'h55);
      send_pixel(7'h2A);
      drain();
      // Shrinking the frame below the pixels already taken ends it on the next pixel.
      write_reg(CSR_IMAGE_WIDTH, 16'd1);
      write_reg(CSR_IMAGE_HEIGHT, 16'd1);
      send_random(1);
      drain();
      write_reg(CSR_IMAGE_WIDTH, 16'hFFFF);
      write_reg(CSR_IMAGE_HEIGHT, 16'hFFFF);
      write_reg(CSR_FRAME_DELAY, 16'hFFFF);
      write_reg(CSR_FRAME_TOTAL, 16'd0);
      send_random(3);
      drain();
      write_reg(CSR_IMAGE_WIDTH, 16'd0);
      send_random(2);
      drain();
      write_reg(CSR_IMAGE_WIDTH, 16'd3);
      write_reg(CSR_IMAGE_HEIGHT, 16'd0);
      send_random(1);
      drain();
      write_reg(CSR_UNMAPPED_LO, 16'hFFFF);
      write_reg(CSR_UNMAPPED_HI, 16'h1234);
      send_random(1);
      drain();
      write_reg(CSR_FRAME_DELAY, 16'd0);
      write_reg(CSR_IMAGE_WIDTH, 16'd1);
      write_reg(CSR_IMAGE_HEIGHT, 16'd1);
      write_reg(CSR_FRAME_TOTAL, 16'd3);
      send_random(4);
      drain();

      // One frame long enough to fill a whole sub-block.
      write_reg(CSR_IMAGE_WIDTH, 16'd128);
      write_reg(CSR_IMAGE_HEIGHT, 16'd1);
      write_reg(CSR_FRAME_TOTAL, 16'd2);
      send_random(128);
      sent = 144;
      drain();

      while (sent < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 3) != 0) begin
            roll = $urandom_range(0, 19);
            if (roll == 0) write_reg(CSR_IMAGE_WIDTH, 16'd0);
            else if (roll == 1) write_reg(CSR_IMAGE_WIDTH, 16'hFFFF);
            else if (roll < 4) write_reg(CSR_IMAGE_WIDTH, 16'($urandom_range(100, 140)));
            else write_reg(CSR_IMAGE_WIDTH, 16'($urandom_range(1, 6)));
         end
         if ($urandom_range(0, 3) != 0) begin
            roll = $urandom_range(0, 19);
            if (roll == 0) write_reg(CSR_IMAGE_HEIGHT, 16'd0);
            else if (roll == 1) write_reg(CSR_IMAGE_HEIGHT, 16'($urandom_range(1, 65535)));
            else write_reg(CSR_IMAGE_HEIGHT, 16'($urandom_range(1, 5)));
         end
         if ($urandom_range(0, 3) != 0)
            write_reg(CSR_FRAME_DELAY, 16'($urandom_range(0, 65535)));
         if ($urandom_range(0, 3) != 0) begin
            roll = $urandom_range(0, 9);
            if (roll < 2) write_reg(CSR_FRAME_TOTAL, 16'd0);
            else if (roll == 2) write_reg(CSR_FRAME_TOTAL, 16'hFFFF);
            else write_reg(CSR_FRAME_TOTAL, 16'($urandom_range(1, 4)));
         end
         if ($urandom_range(0, 7) == 0)
            write_reg(CSR_INDEX_BITS'($urandom_range(4, 255)), 16'($urandom_range(0, 65535)));
         roll = $urandom_range(1, 30);
         send_random(roll);
         sent += roll;
         drain();
      end

      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/ugff_pkg.sv
design/ugff_front.sv
design/ugff_queue.sv
design/ugff_back.sv
design/uncompressed_gif_frame_framer_unit.sv
design/ugff_checker.sv
tb/testbench.sv
